// File: src/tpts_pkg.sv
// Shared widths, codes and position encodings for the threshold position trade block.
`default_nettype none

package tpts_pkg;

  localparam int unsigned SigW    = 32;
  localparam int unsigned PriceW  = 31;
  localparam int unsigned LatW    = 16;
  localparam int unsigned ScoreW  = 48;
  localparam int unsigned LastW   = 34;
  localparam int unsigned TpW     = 33;
  localparam int unsigned ProfitW = 48;
  localparam int unsigned CountW  = 32;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_e;

  localparam logic [1:0] POS_FLAT  = 2'b00;
  localparam logic [1:0] POS_LONG  = 2'b01;
  localparam logic [1:0] POS_SHORT = 2'b11;

endpackage

`default_nettype wire

// File: src/threshold_position_trade_sim.sv
// Top level of the threshold position trade block: score pipeline and position state.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------------
//  cfg     | in        | cfg_we_i                  | cfg_wdata_i (fee)
//  in      | in        | in_valid_i / in_ready_o   | signal, mid_price, half_spread, latency
//  out     | out       | out_valid_o / out_ready_i | action, position_now, trade_price,
//          |           |                           | profit_now, trades_now
//
// Three register stages: input beat, score and prices (one 32x32 multiply and the
// threshold compares), then the position update that loads the result register.
// One beat per cycle sustained while out_ready_i is high.
// Reset clears the position state, the fee and all stage valid bits.
// Each stage advances when the one after it is empty or draining, so a beat is taken
// while a finished result waits as long as an earlier stage has room.
`default_nettype none

module threshold_position_trade_sim
  import tpts_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [PriceW-1:0]         cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic signed [SigW-1:0]    signal_i,
  input  wire logic [PriceW-1:0]         mid_price_i,
  input  wire logic [PriceW-1:0]         half_spread_i,
  input  wire logic [LatW-1:0]           latency_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic [1:0]                action_o,
  output      logic signed [1:0]         position_now_o,
  output      logic signed [TpW-1:0]     trade_price_o,
  output      logic signed [ProfitW-1:0] profit_now_o,
  output      logic [CountW-1:0]         trades_now_o
);

  logic [PriceW-1:0] fee_q;

  // stage 1: captured input beat
  logic                   s1_valid_q;
  logic signed [SigW-1:0] s1_sig_q;
  logic [PriceW-1:0]      s1_mid_q;
  logic [PriceW-1:0]      s1_spr_q;
  logic [LatW-1:0]        s1_lat_q;

  // stage 2: decisions and candidate prices
  logic                    s2_valid_q;
  logic                    s2_buy_q;
  logic                    s2_sell_q;
  logic signed [LastW-1:0] s2_bprice_q;
  logic signed [LastW-1:0] s2_sprice_q;
  logic [LatW-1:0]         s2_lat_q;

  // result register and running state
  logic                      out_valid_q;
  action_e                   action_q;
  logic [1:0]                pos_q;
  logic [LatW-1:0]           skip_q;
  logic signed [ProfitW-1:0] profit_q;
  logic [CountW-1:0]         count_q;
  logic signed [LastW-1:0]   last_q;

  logic s2_ready, s1_ready, s1_load, s2_load, out_load;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s2_valid_q || s2_ready;
  assign in_ready_o = !s1_valid_q || s1_ready;
  assign s1_load    = in_valid_i && in_ready_o;
  assign s2_load    = s1_valid_q && s1_ready;
  assign out_load   = s2_valid_q && s2_ready;

  // score and threshold compare
  logic signed [63:0]       prod;
  logic signed [ScoreW-1:0] score;
  logic [PriceW:0]          thr;
  logic signed [ScoreW-1:0] thr_pos, thr_neg;
  logic                     buy_c, sell_c;
  logic [LastW-1:0]         bprice_c, sprice_c;

  assign prod    = 64'(s1_sig_q) * 64'($signed({1'b0, s1_mid_q}));
  assign score   = prod[63:16];  // arithmetic shift rounds toward minus infinity
  assign thr     = {1'b0, s1_spr_q} + {1'b0, fee_q};
  assign thr_pos = $signed({{(ScoreW-PriceW-1){1'b0}}, thr});
  assign thr_neg = -thr_pos;
  assign buy_c   = score > thr_pos;
  assign sell_c  = score < thr_neg;
  assign bprice_c = {3'b000, s1_mid_q} + {3'b000, s1_spr_q} + {3'b000, fee_q};
  assign sprice_c = {3'b000, s1_mid_q} - {3'b000, s1_spr_q} - {3'b000, fee_q};

  // position update
  action_e                   action_d;
  logic [1:0]                pos_d;
  logic [LatW-1:0]           skip_d;
  logic signed [ProfitW-1:0] profit_d;
  logic [CountW-1:0]         count_d;
  logic signed [LastW-1:0]   last_d;
  logic                      do_buy, do_sell, two_units;
  logic signed [LastW-1:0]   price;
  logic signed [ProfitW+1:0] cash, psum;
  logic [CountW:0]           csum;

  always_comb begin
    do_buy    = (skip_q == '0) && s2_buy_q && (pos_q != POS_LONG);
    do_sell   = (skip_q == '0) && !s2_buy_q && s2_sell_q && (pos_q != POS_SHORT);
    two_units = do_buy ? (pos_q == POS_SHORT) : (pos_q == POS_LONG);
    price     = do_buy ? s2_bprice_q : s2_sprice_q;
    cash      = two_units ? {{(ProfitW-LastW+1){price[LastW-1]}}, price, 1'b0}
                          : {{(ProfitW-LastW+2){price[LastW-1]}}, price};
    psum      = do_buy ? ({{2{profit_q[ProfitW-1]}}, profit_q} - cash)
                       : ({{2{profit_q[ProfitW-1]}}, profit_q} + cash);
    csum      = {1'b0, count_q} + (two_units ? (CountW+1)'(2) : (CountW+1)'(1));

    action_d = ACT_NONE;
    pos_d    = pos_q;
    skip_d   = skip_q;
    profit_d = profit_q;
    count_d  = count_q;
    last_d   = last_q;

    if (skip_q != '0) begin
      skip_d = skip_q - 1'b1;
    end else if (do_buy || do_sell) begin
      action_d = do_buy ? ACT_BUY : ACT_SELL;
      pos_d    = do_buy ? POS_LONG : POS_SHORT;
      skip_d   = s2_lat_q;
      last_d   = price;
      // saturate to the signed 48-bit range
      if (psum[ProfitW+1:ProfitW-1] == 3'b000 || psum[ProfitW+1:ProfitW-1] == 3'b111) begin
        profit_d = psum[ProfitW-1:0];
      end else if (psum[ProfitW+1]) begin
        profit_d = {1'b1, {(ProfitW-1){1'b0}}};
      end else begin
        profit_d = {1'b0, {(ProfitW-1){1'b1}}};
      end
      count_d = csum[CountW] ? '1 : csum[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fee_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      action_q    <= ACT_NONE;
      pos_q       <= POS_FLAT;
      skip_q      <= '0;
      profit_q    <= '0;
      count_q     <= '0;
      last_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        fee_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s2_ready) begin
        out_valid_q <= s2_valid_q;
      end
      if (out_load) begin
        action_q <= action_d;
        pos_q    <= pos_d;
        skip_q   <= skip_d;
        profit_q <= profit_d;
        count_q  <= count_d;
        last_q   <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_sig_q <= signal_i;
      s1_mid_q <= mid_price_i;
      s1_spr_q <= half_spread_i;
      s1_lat_q <= latency_i;
    end
    if (s2_load) begin
      s2_buy_q    <= buy_c;
      s2_sell_q   <= sell_c;
      s2_bprice_q <= $signed(bprice_c);
      s2_sprice_q <= $signed(sprice_c);
      s2_lat_q    <= s1_lat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = action_q;
  assign position_now_o = pos_q;
  assign profit_now_o   = profit_q;
  assign trades_now_o   = count_q;
  // clamp the held price to the signed 33-bit range
  assign trade_price_o  = (last_q[LastW-1] == last_q[LastW-2]) ? last_q[TpW-1:0]
                        : (last_q[LastW-1] ? {1'b1, {(TpW-1){1'b0}}}
                                           : {1'b0, {(TpW-1){1'b1}}});

  a_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'b10)
    else $error("position register holds an illegal code");

  a_buy_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && action_q == ACT_BUY) |-> (pos_q == POS_LONG))
    else $error("buy result without long position");

  a_skip_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && skip_q != '0) |=> (action_q == ACT_NONE && $stable(pos_q)))
    else $error("trade taken while skipping");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |=> (count_q >= $past(count_q)))
    else $error("trade count went down");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("empty input stage refuses a beat");

endmodule

`default_nettype wire

// File: verif/threshold_position_trade_sim_tb.sv
// Self-checking bench for the threshold position trade block, with a position ledger as scoreboard.
module threshold_position_trade_sim_tb;
  import tpts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_SAMPLES = 225;
  localparam logic [PriceW-1:0] ONE_Q = 31'h0001_0000;
  localparam logic [PriceW-1:0] PRICE_TOP = 31'h7FFF_FFFF;
  localparam logic signed [SigW-1:0] SIG_TOP = 32'sh7FFF_FFFF;
  localparam logic signed [SigW-1:0] SIG_BOTTOM = 32'sh8000_0000;

  typedef struct {
    logic signed [SigW-1:0] signal;
    logic [PriceW-1:0]      mid_price;
    logic [PriceW-1:0]      half_spread;
    logic [LatW-1:0]        latency;
  } sample_t;

  typedef struct {
    logic [1:0]                action;
    logic signed [1:0]         position;
    logic signed [TpW-1:0]     price;
    logic signed [ProfitW-1:0] profit;
    logic [CountW-1:0]         trades;
  } fill_t;

  class trade_ledger;
    logic [PriceW-1:0] fee;
    int                position;
    logic [LatW-1:0]   skip_left;
    longint            profit;
    longint            trades;
    longint            last_price;
    fill_t             expected_fills[$];
    int                errors;

    function new();
      fee = '0;
      position = 0;
      skip_left = '0;
      profit = 0;
      trades = 0;
      last_price = 0;
      errors = 0;
    endfunction

    function longint score_of(sample_t s);
      longint sig;
      longint mid;
      sig = s.signal;
      mid = s.mid_price;
      return (sig * mid) >>> 16;
    endfunction

    function longint threshold_of(sample_t s);
      longint spr;
      longint fee_q;
      spr = s.half_spread;
      fee_q = fee;
      return spr + fee_q;
    endfunction

    function bit trades_on(sample_t s);
      longint score;
      longint thr;
      score = score_of(s);
      thr = threshold_of(s);
      return (skip_left == 0) && ((score > thr && position < 1) || (score < -thr && position > -1));
    endfunction

    function void book(longint units, longint price);
      profit = profit + units * price;
      if (profit > 64'sd140737488355327) profit = 64'sd140737488355327;
      if (profit < -64'sd140737488355328) profit = -64'sd140737488355328;
      trades = trades + ((units < 0) ? -units : units);
      if (trades > 64'sd4294967295) trades = 64'sd4294967295;
    endfunction

    function void note_sample(sample_t s);
      longint score;
      longint thr;
      longint mid;
      longint spr;
      longint fee_q;
      longint tp;
      fill_t  f;
      f.action = ACT_NONE;
      mid = s.mid_price;
      spr = s.half_spread;
      fee_q = fee;
      if (skip_left != 0) begin
        skip_left--;
      end else begin
        score = score_of(s);
        thr = threshold_of(s);
        if (score > thr) begin
          if (position < 1) begin
            last_price = mid + spr + fee_q;
            // buying costs cash: negative units into the book
            book(-(1 - position), last_price);
            position = 1;
            skip_left = s.latency;
            f.action = ACT_BUY;
          end
        end else if (score < -thr) begin
          if (position > -1) begin
            last_price = mid - spr - fee_q;
            book(position + 1, last_price);
            position = -1;
            skip_left = s.latency;
            f.action = ACT_SELL;
          end
        end
      end
      tp = last_price;
      if (tp > 64'sd4294967295) tp = 64'sd4294967295;
      if (tp < -64'sd4294967296) tp = -64'sd4294967296;
      f.position = position[1:0];
      f.price = tp[TpW-1:0];
      f.profit = profit[ProfitW-1:0];
      f.trades = trades[CountW-1:0];
      expected_fills.push_back(f);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                 $signed(want), $signed(got));
      end
    endfunction

    function void check_fill(fill_t got);
      fill_t want;
      if (expected_fills.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected", $time);
        return;
      end
      want = expected_fills.pop_front();
      compare("action", 64'(want.action), 64'(got.action));
      compare("position_now", 64'(want.position), 64'(got.position));
      compare("trade_price", 64'(want.price), 64'(got.price));
      compare("profit_now", 64'(want.profit), 64'(got.profit));
      compare("trades_now", 64'(want.trades), 64'(got.trades));
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [PriceW-1:0]         cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [SigW-1:0]    signal = '0;
  logic [PriceW-1:0]         mid_price = '0;
  logic [PriceW-1:0]         half_spread = '0;
  logic [LatW-1:0]           latency = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                action;
  logic signed [1:0]         position_now;
  logic signed [TpW-1:0]     trade_price;
  logic signed [ProfitW-1:0] profit_now;
  logic [CountW-1:0]         trades_now;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned cycles = 0;
  trade_ledger ledger;

  threshold_position_trade_sim dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .signal_i      (signal),
    .mid_price_i   (mid_price),
    .half_spread_i (half_spread),
    .latency_i     (latency),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .action_o      (action),
    .position_now_o(position_now),
    .trade_price_o (trade_price),
    .profit_now_o  (profit_now),
    .trades_now_o  (trades_now)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin : watch_results
    fill_t got;
    if (rst_n && out_valid && out_ready) begin
      got.action = action;
      got.position = position_now;
      got.price = trade_price;
      got.profit = profit_now;
      got.trades = trades_now;
      ledger.check_fill(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic push_sample(input sample_t s);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    signal <= s.signal;
    mid_price <= s.mid_price;
    half_spread <= s.half_spread;
    latency <= s.latency;
    do @(posedge clk); while (!in_ready);
    ledger.note_sample(s);
    @(negedge clk);
  endtask

  // Drain all results, then hold off so the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.expected_fills.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_fee(input logic [PriceW-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    ledger.fee = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SigW-1:0] pick_signal_extreme();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return SIG_TOP;
      default: return SIG_BOTTOM;
    endcase
  endfunction

  function automatic logic [PriceW-1:0] pick_price_extreme();
    return $urandom_range(0, 1) ? PRICE_TOP : '0;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    longint  thr;
    longint  offset;
    logic [15:0] short_sig;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    s.signal = $urandom;
    s.mid_price = PriceW'($urandom);
    s.half_spread = PriceW'($urandom);
    s.latency = LatW'($urandom);
    case (mode)
      4, 5, 6: begin
        // unit price makes the score equal the signal: probe the threshold edges
        s.mid_price = ONE_Q;
        s.half_spread = PriceW'($urandom_range(0, 1 << 20));
        thr = ledger.threshold_of(s);
        if (thr < 64'sd2147483640) begin
          offset = longint'($urandom_range(0, 4)) - 2;
          s.signal = SigW'($urandom_range(0, 1) ? (thr + offset) : (-thr + offset));
        end
      end
      7, 8: begin
        short_sig = 16'($urandom);
        s.signal = {{16{short_sig[15]}}, short_sig};
        s.mid_price = PriceW'($urandom_range(0, 1 << 20));
        s.half_spread = PriceW'($urandom_range(0, 1 << 12));
      end
      9: begin
        s.signal = pick_signal_extreme();
        s.mid_price = pick_price_extreme();
        s.half_spread = pick_price_extreme();
      end
      default: ;
    endcase
    // keep skip runs short when this sample will trade
    if (ledger.trades_on(s))
      s.latency = LatW'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 30)
                                                    : $urandom_range(0, 3));
    return s;
  endfunction

  task automatic run_directed();
    sample_t plan[$];
    plan.push_back(sample_t'{'0, '0, '0, '0});
    plan.push_back(sample_t'{32'sd1, 31'd1, '0, '0});
    plan.push_back(sample_t'{-32'sd1, 31'd1, '0, '0});
    plan.push_back(sample_t'{32'sh0001_0000, ONE_Q, '0, '0});
    plan.push_back(sample_t'{32'sh0001_0000, ONE_Q, '0, '0});
    plan.push_back(sample_t'{-32'sh0001_0000, ONE_Q, '0, 16'd2});
    plan.push_back(sample_t'{SIG_TOP, PRICE_TOP, '0, 16'hFFFF});
    plan.push_back(sample_t'{SIG_TOP, PRICE_TOP, '0, 16'hFFFF});
    plan.push_back(sample_t'{SIG_TOP, PRICE_TOP, PRICE_TOP, '0});
    plan.push_back(sample_t'{SIG_BOTTOM, PRICE_TOP, PRICE_TOP, 16'd1});
    plan.push_back(sample_t'{32'sh0001_0000, ONE_Q, '0, '0});
    plan.push_back(sample_t'{32'sh0002_0000, ONE_Q, 31'h0002_0000, '0});
    plan.push_back(sample_t'{32'sh0002_0001, ONE_Q, 31'h0002_0000, '0});
    plan.push_back(sample_t'{-32'sh0002_0000, ONE_Q, 31'h0002_0000, '0});
    plan.push_back(sample_t'{-32'sh0002_0001, ONE_Q, 31'h0002_0000, '0});
    plan.push_back(sample_t'{SIG_BOTTOM, '0, '0, '0});
    plan.push_back(sample_t'{SIG_TOP, PRICE_TOP, '0, '0});
    plan.push_back(sample_t'{SIG_BOTTOM, ONE_Q, PRICE_TOP, 16'd3});
    repeat (3) plan.push_back(sample_t'{SIG_TOP, PRICE_TOP, '0, 16'hFFFF});
    plan.push_back(sample_t'{SIG_TOP, PRICE_TOP, '0, '0});
    foreach (plan[i]) push_sample(plan[i]);
  endtask

  initial begin
    logic [PriceW-1:0] fee_plan [6];
    ledger = new();
    fee_plan[0] = '0;
    fee_plan[1] = PRICE_TOP;
    fee_plan[2] = PriceW'($urandom);
    fee_plan[3] = ONE_Q;
    fee_plan[4] = PriceW'($urandom_range(0, 1 << 20));
    fee_plan[5] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle = 35;
        recv_idle = 54;
      end else if (phase < 4) begin
        send_idle = 54;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      settle();
      write_fee(fee_plan[phase]);
      if (phase == 0) run_directed();
      repeat (PHASE_SAMPLES) push_sample(random_sample());
    end
    in_valid <= 1'b0;
    while (ledger.expected_fills.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (ledger.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/tpts_pkg.sv
src/threshold_position_trade_sim.sv
verif/threshold_position_trade_sim_tb.sv
